/* rtl/core/upd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types for the URL percent decoder: the result bundle that one input
// byte produces and the push port of the bundle queue.
// ----------------------------------------------------------------------------
package upd_pkg;

   // A single input byte produces at most this many results
   localparam int MaxResults = 3;

   // Up to three result bytes; last and bad apply to the final one only
   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;
      logic [1:0]                 count;
      logic                       last;
      logic                       bad;
   } upd_entry_type;

   typedef struct packed {
      logic          valid;
      upd_entry_type entry;
   } upd_push_type;

endpackage
`default_nettype wire

/* rtl/core/upd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// upd_front
// Accepts raw bytes, tracks the escape state and turns each byte into a
// bundle of zero to three results for the queue.
// ----------------------------------------------------------------------------
module upd_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [7:0]            req_in_byte,
   input  wire logic                  req_in_last,
   input  wire logic                  full,
   output      upd_pkg::upd_push_type push
);

   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharPlus    = 8'h2B;
   localparam logic [7:0] CharSpace   = 8'h20;

   localparam logic [1:0] HeldNone    = 2'd0;
   localparam logic [1:0] HeldPercent = 2'd1;
   localparam logic [1:0] HeldDigit   = 2'd2;

   function automatic logic is_hex(input logic [7:0] b);
      logic r;
      unique case (b) inside
         [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: r = 1'b1;
         default:                                     r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [3:0] r;
      if (b <= 8'h39) begin
         r = b[3:0];
      end else begin
         r = b[3:0] + 4'd9;
      end
      return r;
   endfunction

   function automatic logic is_allowed(input logic [7:0] b);
      logic r;
      unique case (b) inside
         8'h21, [8'h23:8'h3B], 8'h3D, [8'h3F:8'h5B], 8'h5D, 8'h5F,
         [8'h61:8'h7A], 8'h7E: r = 1'b1;
         default:              r = 1'b0;
      endcase
      return r;
   endfunction

   logic [1:0] held_count_ff, held_count_in;
   logic [7:0] held_digit_ff, held_digit_in;
   logic       skip_rest_ff, skip_rest_in;
   logic       accept;

   upd_pkg::upd_entry_type entry;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic       do_fresh;
      logic [1:0] n;
      logic [7:0] b;
      do_fresh       = 1'b0;
      n              = 2'd0;
      b              = req_in_byte;
      entry          = '0;
      held_count_in  = held_count_ff;
      held_digit_in  = held_digit_ff;
      skip_rest_in   = skip_rest_ff;

      if (skip_rest_ff) begin
         // drop everything up to the end of the aborted string
         if (req_in_last) begin
            skip_rest_in  = 1'b0;
            held_count_in = HeldNone;
         end
      end else begin
         case (held_count_ff)
            HeldPercent: begin
               if (is_hex(b) && !req_in_last) begin
                  held_count_in = HeldDigit;
                  held_digit_in = b;
               end else begin
                  held_count_in      = HeldNone;
                  entry.bytes[n]     = CharPercent;
                  n                  = n + 2'd1;
                  do_fresh           = 1'b1;
               end
            end
            HeldDigit: begin
               held_count_in = HeldNone;
               if (is_hex(b)) begin
                  entry.bytes[n] = {hex_value(held_digit_ff), hex_value(b)};
                  n              = n + 2'd1;
               end else begin
                  entry.bytes[n] = CharPercent;
                  n              = n + 2'd1;
                  entry.bytes[n] = held_digit_ff;
                  n              = n + 2'd1;
                  do_fresh       = 1'b1;
               end
            end
            default: begin
               held_count_in = HeldNone;
               do_fresh      = 1'b1;
            end
         endcase

         if (do_fresh) begin
            if (!is_allowed(b)) begin
               entry.bytes[n] = 8'h00;
               n              = n + 2'd1;
               entry.bad      = 1'b1;
               held_count_in  = HeldNone;
               skip_rest_in   = !req_in_last;
            end else if (b == CharPercent) begin
               if (req_in_last) begin
                  entry.bytes[n] = CharPercent;
                  n              = n + 2'd1;
               end else begin
                  held_count_in = HeldPercent;
               end
            end else begin
               entry.bytes[n] = (b == CharPlus) ? CharSpace : b;
               n              = n + 2'd1;
            end
         end

         if (req_in_last) begin
            held_count_in = HeldNone;
         end
      end

      entry.count = n;
      // an error result closes its string
      entry.last  = req_in_last || entry.bad;
   end

   assign push.valid = accept && (entry.count != 2'd0);
   assign push.entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= HeldNone;
         held_digit_ff <= 8'h00;
         skip_rest_ff  <= 1'b0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         held_digit_ff <= held_digit_in;
         skip_rest_ff  <= skip_rest_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/upd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// upd_queue
// Short register queue of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
module upd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire upd_pkg::upd_push_type  push,
   output      logic                   full,
   input  wire logic                   pop,
   output      logic                   empty,
   output      upd_pkg::upd_entry_type pop_data
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   upd_pkg::upd_entry_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push.valid && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/upd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// upd_back
// Takes bundles from the queue and hands out their results one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module upd_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   empty,
   input  wire upd_pkg::upd_entry_type pop_data,
   output      logic                   pop,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [7:0]             rsp_out_byte,
   output      logic                   rsp_out_last,
   output      logic                   rsp_bad_char
);

   upd_pkg::upd_entry_type cur_ff;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] pos_ff, pos_in;
   logic       is_final;
   logic       accept;

   assign is_final  = (pos_ff == cur_ff.count - 2'd1);
   assign accept    = cur_valid_ff && rsp_ready;
   assign pop       = !empty && (!cur_valid_ff || (accept && is_final));

   assign rsp_valid    = cur_valid_ff;
   assign rsp_out_byte = cur_ff.bytes[pos_ff];
   assign rsp_out_last = cur_ff.last && is_final;
   assign rsp_bad_char = cur_ff.bad && is_final;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         pos_in       = 2'd0;
      end else if (accept) begin
         // advance within the bundle, or go idle after its final result
         if (is_final) begin
            cur_valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pos_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= pop_data;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/url_percent_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent decoder with a decoupled front end and result queue.
// ----------------------------------------------------------------------------
// The block accepts one encoded byte per cycle whenever its bundle queue has
// room, and emits decoded bytes one per cycle while rsp_ready is high. Each
// input byte yields zero to three results ('%' escapes that break up release
// held characters), so a burst of bytes that each yield two or three results
// is paced by the output serializer, which hands out one result per cycle
// while rsp_ready is high; over a whole string the results never outnumber the
// inputs. A result is held in the queue and then in the output register
// before it appears. The rest of a string after a disallowed byte is taken
// whenever the queue has room, and dropped. No clearing pass follows reset.
module url_percent_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_out_byte,
   output      logic       rsp_out_last,
   output      logic       rsp_bad_char
);

   upd_pkg::upd_push_type  push;
   upd_pkg::upd_entry_type pop_data;
   logic                   full;
   logic                   empty;
   logic                   pop;

   upd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .full        (full),
      .push        (push)
   );

   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .pop_data (pop_data)
   );

   upd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (empty),
      .pop_data     (pop_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_bad_char (rsp_bad_char)
   );

endmodule
`default_nettype wire

/* rtl/core/upd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks for the URL percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module upd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_last,
   input wire logic       rsp_bad_char
);

   // an error result always closes its string
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_char |-> rsp_out_last)
      else $error("error item without last flag");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_char |-> rsp_out_byte == 8'h00)
      else $error("error item with nonzero byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_last) && $stable(rsp_bad_char))
      else $error("stalled item changed");

   // nothing can be pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("item shown right after reset");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last),
   .rsp_bad_char (rsp_bad_char)
);
`default_nettype wire
